### rtl/drq_pkg.sv
// Shared types, constants and helpers for the deferred release queue.
`default_nettype none
package drq_pkg;

    localparam int DEPTH       = 16;
    localparam int HANDLE_BITS = 16;
    localparam int DELAY_BITS  = 8;
    localparam int PTR_BITS    = $clog2(DEPTH);
    localparam int TDATA_BITS  = ((HANDLE_BITS + 7) / 8) * 8;
    localparam int CMD_BITS    = 2;
    localparam int STATUS_BITS = 3;

    localparam logic [DELAY_BITS-1:0] DEFER_RESET = DELAY_BITS'(2);

    typedef logic [PTR_BITS-1:0]    ptr_t;
    typedef logic [HANDLE_BITS-1:0] handle_t;
    typedef logic [DELAY_BITS-1:0]  count_t;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_RELEASE = 2'd0,
        CMD_TICK    = 2'd1,
        CMD_CLEAR   = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_ACCEPTED = 3'd0,
        ST_DROPPED  = 3'd1,
        ST_NULL     = 3'd2,
        ST_FREED    = 3'd3,
        ST_NOTHING  = 3'd4,
        ST_CLEARED  = 3'd5
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    store;
        logic    clear;
        logic    step;
        logic    emit;
        status_t emit_status;
        logic    emit_pend;
        logic    emit_last;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        cmd_t item_cmd;
        logic handle_null;
        logic ring_full;
        logic cnt_zero;
        logic dec_zero;
        logic walk_end;
        logic pend_valid;
        logic out_free;
    } dp_status_t;

    function automatic ptr_t next_ptr(input ptr_t p);
        ptr_t r;
        if (p == PTR_BITS'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_BITS'(1);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### rtl/drq_datapath.sv
// Datapath: ring stores, pointers, walk cursor, pending result and output register.
`default_nettype none
module drq_datapath (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [drq_pkg::DELAY_BITS-1:0]       cfg_wr_data,
    input  wire logic [drq_pkg::CMD_BITS-1:0]         in_cmd,
    input  wire logic [drq_pkg::HANDLE_BITS-1:0]      in_handle,
    input  wire drq_pkg::dp_cmd_t                     cmd,
    output drq_pkg::dp_status_t                       status,
    input  wire logic                                 out_ready,
    output logic                                      out_valid,
    output logic [drq_pkg::STATUS_BITS-1:0]           out_status,
    output logic [drq_pkg::HANDLE_BITS-1:0]           out_handle,
    output logic                                      out_last
);
    import drq_pkg::*;

    handle_t           handle_mem [DEPTH];
    count_t            cnt_mem    [DEPTH];
    logic [DEPTH-1:0]  valid_reg;

    ptr_t      wp_reg, rp_reg, cur_reg;
    count_t    defer_reg;
    cmd_t      item_cmd_reg;
    handle_t   item_handle_reg;
    count_t    cnt_q_reg;
    handle_t   handle_q_reg;
    logic      pend_valid_reg;
    handle_t   pend_handle_reg;
    logic      out_valid_reg;
    status_t   out_status_reg;
    handle_t   out_handle_reg;
    logic      out_last_reg;

    ptr_t      cur_nxt;
    ptr_t      rd_addr;
    count_t    dec;
    count_t    defer_eff;
    logic      out_free;

    assign cur_nxt   = next_ptr(cur_reg);
    assign rd_addr   = cmd.load ? rp_reg : cur_nxt;
    assign dec       = cnt_q_reg - DELAY_BITS'(1);
    assign defer_eff = (defer_reg == '0) ? DELAY_BITS'(1) : defer_reg;
    assign out_free  = !out_valid_reg || out_ready;

    assign status.item_cmd    = item_cmd_reg;
    assign status.handle_null = (item_handle_reg == '0);
    assign status.ring_full   = (wp_reg == rp_reg) && (cnt_q_reg != '0);
    assign status.cnt_zero    = (cnt_q_reg == '0);
    assign status.dec_zero    = (cnt_q_reg == DELAY_BITS'(1));
    assign status.walk_end    = (cur_nxt == wp_reg);
    assign status.pend_valid  = pend_valid_reg;
    assign status.out_free    = out_free;

    // Store writes and registered reads; the stores carry no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            handle_mem[wp_reg] <= item_handle_reg;
            cnt_mem[wp_reg]    <= defer_eff;
        end
        else if (cmd.step)
        begin
            cnt_mem[cur_reg] <= dec;
        end
        if (cmd.load || cmd.step)
        begin
            cnt_q_reg    <= valid_reg[rd_addr] ? cnt_mem[rd_addr] : '0;
            handle_q_reg <= handle_mem[rd_addr];
        end
        if (cmd.load)
        begin
            item_cmd_reg    <= cmd_t'(in_cmd);
            item_handle_reg <= in_handle;
        end
        if (cmd.step && status.dec_zero)
        begin
            pend_handle_reg <= handle_q_reg;
        end
        if (cmd.emit)
        begin
            out_status_reg <= cmd.emit_status;
            out_handle_reg <= cmd.emit_pend ? pend_handle_reg : '0;
            out_last_reg   <= cmd.emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            wp_reg         <= '0;
            rp_reg         <= '0;
            cur_reg        <= '0;
            defer_reg      <= DEFER_RESET;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                defer_reg <= cfg_wr_data;
            end
            if (cmd.clear)
            begin
                valid_reg <= '0;
                wp_reg    <= '0;
                rp_reg    <= '0;
            end
            else if (cmd.store)
            begin
                valid_reg[wp_reg] <= 1'b1;
                wp_reg            <= next_ptr(wp_reg);
            end
            else if (cmd.step)
            begin
                valid_reg[cur_reg] <= 1'b1;
                if (status.dec_zero)
                begin
                    rp_reg <= cur_nxt;
                end
            end
            if (cmd.load)
            begin
                cur_reg <= rp_reg;
            end
            else if (cmd.step)
            begin
                cur_reg <= cur_nxt;
            end
            // A newly freed entry becomes pending in the same cycle as the older one is sent.
            if (cmd.step && status.dec_zero)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.emit && cmd.emit_pend)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_handle = out_handle_reg;
    assign out_last   = out_last_reg;

    a_emit_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> out_free)
        else $error("result written while the output register was occupied");

    a_store_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> (!status.ring_full && !status.handle_null))
        else $error("handle stored into a full ring or null handle stored");

    a_clear_resets_pointers: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> (wp_reg == '0 && rp_reg == '0 && valid_reg == '0))
        else $error("clear did not empty the ring");

    a_handle_only_when_freed: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.emit_status != ST_FREED) |=> (out_handle_reg == '0))
        else $error("handle shown on a result that frees nothing");

endmodule
`default_nettype wire

### rtl/drq_ctrl.sv
// Controller state machine sequencing releases, ticks and clears.
`default_nettype none
module drq_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire drq_pkg::dp_status_t  status,
    output drq_pkg::dp_cmd_t          cmd
);
    import drq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_LOOK   = 4'b0010,
        S_WALK   = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   need_emit;

    assign in_ready  = (state_reg == S_IDLE);
    assign need_emit = status.dec_zero && status.pend_valid;

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.emit_status = ST_NOTHING;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (status.item_cmd == CMD_TICK && !status.cnt_zero)
                begin
                    state_next = S_WALK;
                end
                else if (status.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                    case (status.item_cmd)
                        CMD_RELEASE:
                        begin
                            if (status.handle_null)
                            begin
                                cmd.emit_status = ST_NULL;
                            end
                            else if (status.ring_full)
                            begin
                                cmd.emit_status = ST_DROPPED;
                            end
                            else
                            begin
                                cmd.store       = 1'b1;
                                cmd.emit_status = ST_ACCEPTED;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            cmd.clear       = 1'b1;
                            cmd.emit_status = ST_CLEARED;
                        end
                        default:
                        begin
                            cmd.emit_status = ST_NOTHING;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                // The previous freed item goes out only once a later one is found,
                // so that the final result can carry the last flag.
                if (!need_emit || status.out_free)
                begin
                    cmd.step = 1'b1;
                    if (need_emit)
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_FREED;
                        cmd.emit_pend   = 1'b1;
                    end
                    if (status.walk_end)
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_last   = 1'b1;
                    cmd.emit_pend   = status.pend_valid;
                    cmd.emit_status = status.pend_valid ? ST_FREED : ST_NOTHING;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == S_LOOK))
        else $error("item taken outside the idle state");

    a_finish_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && status.out_free) |-> (cmd.emit && cmd.emit_last))
        else $error("walk finished without a final result");

endmodule
`default_nettype wire

### rtl/deferred_release_queue.sv
// Top level of the deferred release queue: stream ports, controller and datapath.
`default_nettype none
// Holds up to 16 released handles in a ring, each with a countdown loaded from
// defer_ticks (0 acts as 1). A release, clear or unused command, and a tick that
// finds a zero countdown at the read pointer, pass through the look state and
// give one result. Any other tick walks the ring entries from the read pointer
// to the write pointer (up to 16), since the countdown store has a single
// registered read port and is visited one entry a cycle while no freed handle
// waits for the output register; each freed handle is a result of its own, and
// the final result of every input item has tlast set. Extra cycles are added
// while the output is held by m_tready low. An item is taken whenever the block
// is idle, even while its last result still waits at the output.
module deferred_release_queue (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_wr_en,
    input  wire logic [drq_pkg::DELAY_BITS-1:0]     cfg_wr_data,   // defer_ticks
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [drq_pkg::TDATA_BITS-1:0]     s_tdata,       // handle
    input  wire logic [drq_pkg::CMD_BITS-1:0]       s_tuser,       // cmd
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [drq_pkg::TDATA_BITS-1:0]          m_tdata,       // freed_handle
    output logic [drq_pkg::STATUS_BITS-1:0]         m_tuser,       // status
    output logic                                    m_tlast
);
    import drq_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    handle_t    out_handle;

    drq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    drq_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_cmd      (s_tuser),
        .in_handle   (s_tdata[HANDLE_BITS-1:0]),
        .cmd         (cmd),
        .status      (status),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_status  (m_tuser),
        .out_handle  (out_handle),
        .out_last    (m_tlast)
    );

    assign m_tdata = TDATA_BITS'(out_handle);

endmodule
`default_nettype wire

### tb/deferred_release_queue_tb.sv
// Testbench for the deferred release queue: directed and random items against a ring predictor.
module deferred_release_queue_tb;
    import drq_pkg::*;

    localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 24;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        status_t status;
        handle_t handle;
        logic    last;
    } outcome_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [DELAY_BITS-1:0]  cfg_wr_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [TDATA_BITS-1:0]  s_tdata = '0;
    logic [CMD_BITS-1:0]    s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [TDATA_BITS-1:0]  m_tdata;
    logic [STATUS_BITS-1:0] m_tuser;
    logic                   m_tlast;

    // Predicted ring contents and configuration.
    handle_t  ring_handle [DEPTH];
    count_t   ring_count [DEPTH];
    ptr_t     ring_wr;
    ptr_t     ring_rd;
    count_t   delay_setting;
    outcome_t ring_outcomes [$];

    int error_count = 0;
    int cycle_count = 0;
    int idle_pct = 0;
    int stall_left = 0;

    deferred_release_queue dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic ptr_t slot_after(input ptr_t p);
        ptr_t r;
        r = (p == ptr_t'(DEPTH - 1)) ? '0 : p + ptr_t'(1);
        return r;
    endfunction

    task automatic empty_ring();
        int i;
        for (i = 0; i < DEPTH; i++)
        begin
            ring_handle[i] = '0;
            ring_count[i] = '0;
        end
        ring_wr = '0;
        ring_rd = '0;
    endtask

    // Works out the results of one accepted item and queues them in order.
    task automatic apply_to_ring(input logic [CMD_BITS-1:0] cmd, input handle_t h);
        outcome_t batch [DEPTH];
        ptr_t     cur;
        ptr_t     nxt;
        int       n;
        int       i;
        n = 0;
        case (cmd)
            CMD_RELEASE:
            begin
                batch[0].handle = '0;
                if (h == '0)
                begin
                    batch[0].status = ST_NULL;
                end
                else if (ring_wr == ring_rd && ring_count[ring_rd] != '0)
                begin
                    batch[0].status = ST_DROPPED;
                end
                else
                begin
                    ring_handle[ring_wr] = h;
                    ring_count[ring_wr] = (delay_setting == '0) ? count_t'(1) : delay_setting;
                    ring_wr = slot_after(ring_wr);
                    batch[0].status = ST_ACCEPTED;
                end
                n = 1;
            end
            CMD_TICK:
            begin
                cur = ring_rd;
                if (ring_count[cur] != '0)
                begin
                    do
                    begin
                        nxt = slot_after(cur);
                        ring_count[cur] = ring_count[cur] - count_t'(1);
                        if (ring_count[cur] == '0)
                        begin
                            batch[n].status = ST_FREED;
                            batch[n].handle = ring_handle[cur];
                            n++;
                            ring_handle[cur] = '0;
                            ring_rd = nxt;
                        end
                        cur = nxt;
                    end
                    while (cur != ring_wr && n < DEPTH);
                end
                if (n == 0)
                begin
                    batch[0].status = ST_NOTHING;
                    batch[0].handle = '0;
                    n = 1;
                end
            end
            CMD_CLEAR:
            begin
                empty_ring();
                batch[0].status = ST_CLEARED;
                batch[0].handle = '0;
                n = 1;
            end
            default:
            begin
                batch[0].status = ST_NOTHING;
                batch[0].handle = '0;
                n = 1;
            end
        endcase
        for (i = 0; i < n; i++)
        begin
            batch[i].last = (i == n - 1);
            ring_outcomes.push_back(batch[i]);
        end
    endtask

    // Result checking and output back-pressure share the same clock edge.
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (ring_outcomes.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                begin
                    $display("unexpected result: status %0d handle %h last %0b",
                             m_tuser, m_tdata, m_tlast);
                end
            end
            else
            begin
                want = ring_outcomes.pop_front();
                if (m_tuser != want.status || m_tdata != want.handle || m_tlast != want.last)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                    begin
                        $display({"mismatch: expected status %0d handle %h last %0b, ",
                                  "got status %0d handle %h last %0b"},
                                 want.status, want.handle, want.last,
                                 m_tuser, m_tdata, m_tlast);
                    end
                end
            end
        end
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 2)
        begin
            stall_left = $urandom_range(0, 12);
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Leaves tvalid high after acceptance so that back-to-back items need no toggle.
    task automatic send_item(input logic [CMD_BITS-1:0] cmd, input handle_t h);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= h;
        do
            @(posedge clk);
        while (!s_tready);
        apply_to_ring(cmd, h);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (ring_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_delay(input count_t value);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        delay_setting = value;
    endtask

    function automatic handle_t any_handle();
        int pick;
        handle_t h;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            h = '1;
        else if (pick == 1)
            h = handle_t'(1);
        else
            h = handle_t'($urandom_range(1, 16'hFFFF));
        return h;
    endfunction

    task automatic test_null_and_unused();
        send_item(CMD_RELEASE, '0);
        send_item(CMD_UNUSED, handle_t'(16'h1234));
        // A tick on an empty ring frees nothing.
        send_item(CMD_TICK, '0);
    endtask

    task automatic test_full_ring();
        int i;
        handle_t h;
        // A delay of zero behaves as one, so the single tick frees the whole ring.
        set_delay('0);
        for (i = 0; i < DEPTH; i++)
        begin
            case (i)
                0: h = '1;
                1: h = handle_t'(1);
                2: h = handle_t'(16'hAAAA);
                3: h = handle_t'(16'h5555);
                default: h = any_handle();
            endcase
            send_item(CMD_RELEASE, h);
        end
        send_item(CMD_RELEASE, handle_t'(16'h0BAD));
        send_item(CMD_TICK, '0);
    endtask

    task automatic test_early_expiry();
        // The later entry expires first and the earlier one is skipped for good.
        set_delay(count_t'(3));
        send_item(CMD_RELEASE, handle_t'(16'hC0DE));
        set_delay(count_t'(1));
        send_item(CMD_RELEASE, handle_t'(16'h7E57));
        send_item(CMD_TICK, '0);
        send_item(CMD_TICK, '0);
    endtask

    task automatic test_clear();
        set_delay('1);
        send_item(CMD_RELEASE, handle_t'(16'h8001));
        send_item(CMD_TICK, '0);
        send_item(CMD_CLEAR, '0);
        send_item(CMD_TICK, '0);
    endtask

    task automatic test_random_traffic(input int items, input int delay_lo, input int delay_hi,
                                       input int release_weight, input int gap_pct);
        int i;
        int pick;
        idle_pct = gap_pct;
        set_delay(count_t'(delay_lo));
        for (i = 0; i < items; i++)
        begin
            // An occasional new delay makes younger entries overtake older ones.
            if ($urandom_range(0, 99) < 3)
            begin
                set_delay(count_t'($urandom_range(delay_lo, delay_hi)));
            end
            pick = $urandom_range(0, 99);
            if (pick < release_weight)
                send_item(CMD_RELEASE, any_handle());
            else if (pick < release_weight + 4)
                send_item(CMD_RELEASE, '0);
            else if (pick < release_weight + 7)
                send_item(CMD_CLEAR, handle_t'($urandom));
            else if (pick < release_weight + 9)
                send_item(CMD_UNUSED, handle_t'($urandom));
            else
                send_item(CMD_TICK, handle_t'($urandom));
        end
    endtask

    initial
    begin
        empty_ring();
        delay_setting = DEFER_RESET;
        idle_pct = 25;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_null_and_unused();
        test_full_ring();
        test_early_expiry();
        test_clear();
        test_random_traffic(90, 2, 2, 45, 25);
        test_random_traffic(40, 255, 255, 40, 30);
        test_random_traffic(95, 1, 1, 40, 20);
        test_random_traffic(95, 1, 8, 50, 35);
        test_random_traffic(80, 1, 4, 45, 0);
        wait_drained();
        if (ring_outcomes.size() != 0)
        begin
            error_count++;
        end
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/drq_pkg.sv
rtl/drq_datapath.sv
rtl/drq_ctrl.sv
rtl/deferred_release_queue.sv
tb/deferred_release_queue_tb.sv
